FILE: rtl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the block bitmap allocator: operation and
// status codes, controller states, bitmap geometry and control structs.
// ----------------------------------------------------------------------------
package bba_pkg;

	// Number of tracked blocks (ids 0 to TRACKED_BLOCKS-1)
	localparam int TRACKED_BLOCKS = 255;

	// Bitmap is stored as rows of WORD_W bits
	localparam int WORD_LOG  = 4;
	localparam int WORD_W    = 1 << WORD_LOG;
	localparam int ROWS      = (TRACKED_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LAST_BITS = TRACKED_BLOCKS - (ROWS - 1) * WORD_W;

	// Count width holds TRACKED_BLOCKS itself; index width is at least a byte
	localparam int CNT_W = $clog2(TRACKED_BLOCKS + 1);
	localparam int IDX_W = (CNT_W > 8) ? CNT_W : 8;

	// Valid block positions in the last row
	localparam logic [WORD_W-1:0] LAST_ROW_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
	localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);

	typedef enum logic [1:0] {
		OP_ALLOCATE = 2'd0,
		OP_REQUEST  = 2'd1,
		OP_RELEASE  = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_USED  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;   // capture the input word
		logic rd_en;     // read the current bitmap row
		logic check;     // evaluate the row just read
		logic next_row;  // advance the allocate scan
		logic emit;      // load the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic mem_needed; // input word needs a bitmap access
		logic scan_more;  // allocate found no free bit, rows remain
		logic out_busy;   // output register holds an untaken word
	} sts_t;

endpackage

FILE: rtl/bba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/bba_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap rows in RAM with per-row valid bits, used counter, row evaluation
// for allocate, request and release, and the output register.
// ----------------------------------------------------------------------------
module bba_datapath
	import bba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [7:0]  s_tdata,   // blk_id[7:0]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // result_block[7:0], used_count[15:8], free_count[23:16]
	output logic [1:0]  m_tuser    // status[1:0]
);

	op_t               op_q;
	logic [7:0]        id_q;
	logic [ROW_W-1:0]  row_q;
	status_t           res_status_q;
	logic [7:0]        res_block_q;
	logic [CNT_W-1:0]  used_total_q;
	logic [ROWS-1:0]   row_valid_q;

	// Input decode
	op_t              in_op;
	logic [IDX_W-1:0] in_id_ext;
	logic             in_range;
	logic             in_full;
	logic             mem_needed;

	// Row evaluation
	logic [WORD_W-1:0]   rd_data;
	logic [WORD_W-1:0]   row_data;
	logic [WORD_W-1:0]   pad_mask;
	logic [WORD_W-1:0]   occ;
	logic                free_found;
	logic [WORD_LOG-1:0] free_bit;
	logic [WORD_LOG-1:0] id_bit;
	logic [WORD_W-1:0]   id_onehot;
	logic                id_used;
	logic                we;
	logic [WORD_W-1:0]   wdata;
	logic                cnt_inc;
	logic                cnt_dec;
	logic [IDX_W-1:0]    grant_id;
	logic [IDX_W-1:0]    used_ext;
	logic [IDX_W-1:0]    free_ext;

	function automatic logic [WORD_LOG-1:0] lowest_zero(input logic [WORD_W-1:0] w);
		logic [WORD_LOG-1:0] k;
		k = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!w[b]) begin
				k = WORD_LOG'(b);
			end
		end
		return k;
	endfunction

	// Decode the offered input word
	assign in_op     = op_t'(s_tuser);
	assign in_id_ext = IDX_W'(s_tdata);
	assign in_range  = in_id_ext < IDX_W'(TRACKED_BLOCKS);
	assign in_full   = used_total_q == CNT_W'(TRACKED_BLOCKS);

	always_comb begin
		case (in_op)
			OP_ALLOCATE: mem_needed = !in_full;
			OP_REQUEST:  mem_needed = in_range && (s_tdata != 8'd0);
			OP_RELEASE:  mem_needed = in_range;
			default:     mem_needed = 1'b0;
		endcase
	end

	assign sts.mem_needed = mem_needed;

	// Capture the input word, preset the result, advance the scan row, and update the result on a check
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= in_op;
			id_q <= s_tdata;
			case (in_op)
				OP_ALLOCATE: begin
					row_q        <= '0;
					res_status_q <= in_full ? ST_FULL : ST_OK;
					res_block_q  <= 8'd0;
				end
				OP_REQUEST: begin
					row_q        <= in_id_ext[WORD_LOG +: ROW_W];
					res_status_q <= (in_range && (s_tdata != 8'd0)) ? ST_OK : ST_RANGE;
					res_block_q  <= s_tdata;
				end
				OP_RELEASE: begin
					row_q        <= in_id_ext[WORD_LOG +: ROW_W];
					res_status_q <= in_range ? ST_OK : ST_RANGE;
					res_block_q  <= s_tdata;
				end
				default: begin
					row_q        <= '0;
					res_status_q <= ST_OK;
					res_block_q  <= 8'd0;
				end
			endcase
		end else if (cmd.next_row) begin
			row_q <= row_q + ROW_W'(1);
		end else if (cmd.check && (op_q == OP_ALLOCATE)) begin
			if (free_found) begin
				res_block_q <= grant_id[7:0];
			end else begin
				res_status_q <= ST_FULL;
			end
		end else if (cmd.check && (op_q == OP_REQUEST) && id_used) begin
			res_status_q <= ST_USED;
		end
	end

	// Bitmap row storage
	bba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (row_q),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (row_q),
		.rdata (rd_data)
	);

	// Row evaluation; a row never written reads as all free
	assign row_data   = rd_data & {WORD_W{row_valid_q[row_q]}};
	assign pad_mask   = (row_q == LAST_ROW) ? LAST_ROW_MASK : {WORD_W{1'b1}};
	assign occ        = row_data | ~pad_mask;
	assign free_found = ~&occ;
	assign free_bit   = lowest_zero(occ);
	assign id_bit     = id_q[WORD_LOG-1:0];
	assign id_onehot  = WORD_W'(1) << id_bit;
	assign id_used    = |(row_data & id_onehot);
	assign grant_id   = IDX_W'({row_q, free_bit});

	assign sts.scan_more = (op_q == OP_ALLOCATE) && !free_found && (row_q != LAST_ROW);

	always_comb begin
		we      = 1'b0;
		wdata   = row_data;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		if (cmd.check) begin
			case (op_q)
				OP_ALLOCATE: begin
					we      = free_found;
					wdata   = row_data | (WORD_W'(1) << free_bit);
					cnt_inc = free_found;
				end
				OP_REQUEST: begin
					we      = !id_used;
					wdata   = row_data | id_onehot;
					cnt_inc = !id_used;
				end
				OP_RELEASE: begin
					we      = 1'b1;
					wdata   = row_data & ~id_onehot;
					cnt_dec = id_used;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	// Mark rows written and keep the used count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q  <= '0;
			used_total_q <= '0;
		end else begin
			if (we) begin
				row_valid_q[row_q] <= 1'b1;
			end
			if (cnt_inc) begin
				used_total_q <= used_total_q + CNT_W'(1);
			end else if (cnt_dec) begin
				used_total_q <= used_total_q - CNT_W'(1);
			end
		end
	end

	// Output register
	assign used_ext     = IDX_W'(used_total_q);
	assign free_ext     = IDX_W'(TRACKED_BLOCKS) - used_ext;
	assign sts.out_busy = m_tvalid && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata <= {free_ext[7:0], used_ext[7:0], res_block_q};
			m_tuser <= res_status_q;
		end
	end

endmodule

FILE: rtl/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller of the block bitmap allocator: accepts a word, sequences the
// row reads and checks, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bba_ctrl
	import bba_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = sts.mem_needed ? S_READ : S_EMIT;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = sts.scan_more ? S_READ : S_EMIT;
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
			end
			S_CHECK: begin
				cmd.check    = 1'b1;
				cmd.next_row = sts.scan_more;
			end
			S_EMIT: begin
				cmd.emit = !sts.out_busy;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/block_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator_core
// Free-block bitmap allocator over TRACKED_BLOCKS blocks with allocate,
// request, release and query operations, one result word per input word.
// ----------------------------------------------------------------------------
// One input word is worked on at a time; a new word is taken while the
// previous result still waits in the output register. Query and out-of-range
// words go from accept straight to the result, request and release first do
// one bitmap row read and check. Allocate scans the bitmap rows from the
// lowest, 16 blocks per row, each row a RAM read and then a check, until it
// reaches the row holding the lowest free block, at most all ROWS rows;
// allocate on a full store goes straight to the result. The bitmap starts
// all free after reset with no clearing pass: per-row valid bits mark rows
// that were written.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_core
	import bba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // blk_id[7:0]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // result_block[7:0], used_count[15:8], free_count[23:16]
	output logic [1:0]  m_tuser    // status[1:0]
);

	cmd_t cmd;
	sts_t sts;

	// Sequence the operation
	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Bitmap, counter and output register
	bba_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: tb/block_bitmap_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator_core_tb
// Self-checking bench for the block bitmap allocator. Operation words
// (allocate, request, release, query) go in on the slave stream, and a
// bit-accurate bitmap predictor checks every result word field by field.
// The bench runs a short directed opening, then alternating fill, mixed
// and drain phases that take the store from empty to full and back. The
// sender idles in random bursts and the receiver stalls in shifting patterns.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_core_tb;
	import bba_pkg::*;

	localparam int STALL_LIMIT  = 2000;  // cycles with no word moved
	localparam int TAIL_CYCLES  = 60;    // quiet time after the last result
	localparam int RANDOM_WORDS = 1950;
	localparam int MAX_REPORTS  = 40;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	// One operation word queued for the sender
	typedef struct {
		op_t        op;
		logic [7:0] id;
		bit         hold;  // wait until every result is back before sending
	} op_word_t;

	// One predicted result word
	typedef struct {
		status_t    status;
		logic [7:0] block;
		logic [7:0] used;
		logic [7:0] free;
	} grant_t;

	typedef struct {
		bit [TRACKED_BLOCKS-1:0] map;
		int unsigned             total;
	} blk_map_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // blk_id[7:0]
	logic [1:0]  s_tuser  = '0;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // result_block[7:0], used_count[15:8], free_count[23:16]
	logic [1:0]  m_tuser;         // status[1:0]

	op_word_t op_queue[$];
	grant_t   pending_grants[$];
	blk_map_t plan_map;    // bitmap as the stimulus builder sees it
	blk_map_t alloc_map;   // bitmap as the predictor sees it at each accept

	bit       word_taken = 1'b0;
	int       idle_cycles = 0;
	int       errors = 0;
	int       n_op[4] = '{default: 0};
	int       n_status[4] = '{default: 0};

	block_bitmap_allocator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one operation to a bitmap and return the result word it yields
	function automatic grant_t bitmap_apply(inout blk_map_t bm, input op_t op,
		input logic [7:0] id);
		grant_t g;
		int     k;
		g.status = ST_OK;
		g.block  = '0;
		case (op)
			OP_ALLOCATE: begin
				k = 0;
				while (k < TRACKED_BLOCKS && bm.map[k])
					k++;
				if (k == TRACKED_BLOCKS) begin
					g.status = ST_FULL;
				end else begin
					bm.map[k] = 1'b1;
					bm.total++;
					g.block = 8'(k);
				end
			end
			OP_REQUEST: begin
				g.block = id;
				if (id == 0 || id >= TRACKED_BLOCKS) begin
					g.status = ST_RANGE;
				end else if (bm.map[id]) begin
					g.status = ST_USED;
				end else begin
					bm.map[id] = 1'b1;
					bm.total++;
				end
			end
			OP_RELEASE: begin
				g.block = id;
				if (id >= TRACKED_BLOCKS) begin
					g.status = ST_RANGE;
				end else if (bm.map[id]) begin
					bm.map[id] = 1'b0;
					bm.total--;
				end
			end
			default: ;
		endcase
		g.used = 8'(bm.total);
		g.free = 8'(TRACKED_BLOCKS - bm.total);
		return g;
	endfunction

	// Pick a used block near a random start; any id when the map is empty
	function automatic logic [7:0] pick_used(blk_map_t bm);
		int start;
		int k;
		start = $urandom_range(0, TRACKED_BLOCKS - 1);
		for (int n = 0; n < TRACKED_BLOCKS; n++) begin
			k = (start + n) % TRACKED_BLOCKS;
			if (bm.map[k])
				return 8'(k);
		end
		return 8'(start);
	endfunction

	// Queue a word for the sender and track the bitmap it leaves behind
	task automatic queue_word(op_t op, logic [7:0] id, bit hold);
		op_word_t w;
		w.op   = op;
		w.id   = id;
		w.hold = hold;
		op_queue.push_back(w);
		void'(bitmap_apply(plan_map, op, id));
	endtask

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Sender: bursts of words with random gaps, inputs change on the falling edge
	always @(negedge clk) begin
		op_word_t w;
		static int burst_left = 1;
		static int gap_left = 0;
		if (arst_n) begin
			if (!s_tvalid || word_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (op_queue.size() == 0 ||
						(op_queue[0].hold && pending_grants.size() != 0)) begin
					s_tvalid <= 1'b0;
				end else begin
					w = op_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= w.id;
					s_tuser  <= w.op;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Receiver: switch between randomly chosen stall patterns
	always @(negedge clk) begin
		static rx_mode_t rx_mode = RX_OPEN;
		static int mode_left = 0;
		static int rx_cycle = 0;
		if (arst_n) begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(30, 300);
			end
			mode_left--;
			rx_cycle++;
			case (rx_mode)
				RX_OPEN:     m_tready <= 1'b1;
				RX_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
				default:     m_tready <= (rx_cycle % 5 != 0);
			endcase
		end
	end

	// Monitor: check result words, predict accepted words, watch for a hang
	always @(posedge clk) begin
		grant_t g;
		bit     result_taken;
		if (arst_n) begin
			word_taken = s_tvalid && s_tready;
			result_taken = m_tvalid && m_tready;
			if (result_taken) begin
				if (pending_grants.size() == 0) begin
					report_mismatch("result word with nothing outstanding", 0, m_tdata);
				end else begin
					g = pending_grants.pop_front();
					if (m_tuser != g.status)
						report_mismatch("status", g.status, m_tuser);
					if (m_tdata[7:0] != g.block)
						report_mismatch("result_block", g.block, m_tdata[7:0]);
					if (m_tdata[15:8] != g.used)
						report_mismatch("used_count", g.used, m_tdata[15:8]);
					if (m_tdata[23:16] != g.free)
						report_mismatch("free_count", g.free, m_tdata[23:16]);
				end
				n_status[m_tuser]++;
			end
			if (word_taken) begin
				pending_grants.push_back(bitmap_apply(alloc_map, op_t'(s_tuser), s_tdata));
				n_op[s_tuser]++;
			end
			if (word_taken || result_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int         r;
		int         extra;
		int         phase;
		op_t        op;
		logic [7:0] id;
		bit         hold;

		plan_map  = '{map: '0, total: 0};
		alloc_map = '{map: '0, total: 0};

		// Directed opening: field extremes and each corner of the bitmap rules
		queue_word(OP_QUERY,    8'hFF, 1'b0);
		queue_word(OP_ALLOCATE, 8'hAA, 1'b0);  // block 0 is grantable
		queue_word(OP_REQUEST,  8'd0,  1'b0);  // id zero is out of range
		queue_word(OP_REQUEST,  8'd255, 1'b0); // past the tracked count
		queue_word(OP_REQUEST,  8'd254, 1'b0); // top tracked block
		queue_word(OP_REQUEST,  8'd254, 1'b0); // already in use
		queue_word(OP_REQUEST,  8'd1,  1'b0);
		queue_word(OP_ALLOCATE, 8'h00, 1'b0);  // skips the claimed block 1
		queue_word(OP_REQUEST,  8'd2,  1'b0);  // claimed by allocate
		queue_word(OP_RELEASE,  8'd255, 1'b0); // out of range
		queue_word(OP_RELEASE,  8'd0,  1'b0);
		queue_word(OP_RELEASE,  8'd0,  1'b0);  // release of a free block
		queue_word(OP_ALLOCATE, 8'h55, 1'b0);  // lowest free is 0 again
		queue_word(OP_RELEASE,  8'd254, 1'b0);
		queue_word(OP_RELEASE,  8'd254, 1'b0);
		queue_word(OP_REQUEST,  8'd128, 1'b0);
		queue_word(OP_RELEASE,  8'd127, 1'b0);
		queue_word(OP_REQUEST,  8'd85, 1'b0);
		queue_word(OP_QUERY,    8'h00, 1'b0);

		// Random part: fill to full, mix, drain to empty, mix, and repeat
		phase = 0;
		while (op_queue.size() < RANDOM_WORDS) begin
			hold = 1'b1;  // let the pipeline empty out at each phase change
			case (phase % 4)
				0: begin
					extra = $urandom_range(3, 10);
					while (extra > 0 && op_queue.size() < RANDOM_WORDS) begin
						r = $urandom_range(0, 99);
						id = 8'($urandom_range(0, 255));
						if (r < 75)
							op = OP_ALLOCATE;
						else if (r < 88)
							op = OP_REQUEST;
						else if (r < 94) begin
							op = OP_RELEASE;
							id = pick_used(plan_map);
						end else
							op = OP_QUERY;
						queue_word(op, id, hold);
						hold = 1'b0;
						if (plan_map.total == TRACKED_BLOCKS)
							extra--;
					end
				end
				2: begin
					extra = $urandom_range(3, 10);
					while (extra > 0 && op_queue.size() < RANDOM_WORDS) begin
						r = $urandom_range(0, 99);
						id = 8'($urandom_range(0, 255));
						if (r < 72) begin
							op = OP_RELEASE;
							id = pick_used(plan_map);
						end else if (r < 80)
							op = OP_RELEASE;
						else if (r < 88)
							op = OP_ALLOCATE;
						else if (r < 94)
							op = OP_REQUEST;
						else
							op = OP_QUERY;
						queue_word(op, id, hold);
						hold = 1'b0;
						if (plan_map.total == 0)
							extra--;
					end
				end
				default: begin
					repeat ($urandom_range(100, 200)) begin
						if (op_queue.size() >= RANDOM_WORDS)
							break;
						queue_word(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), hold);
						hold = 1'b0;
					end
				end
			endcase
			phase++;
		end

		// Hold reset, then release it away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_queue.size() != 0 || s_tvalid)
			@(negedge clk);
		while (pending_grants.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (pending_grants.size() != 0)
			report_mismatch("results still outstanding", 0, pending_grants.size());

		$display("Sent %0d words: %0d allocate, %0d request, %0d release, %0d query.",
			n_op[OP_ALLOCATE] + n_op[OP_REQUEST] + n_op[OP_RELEASE] + n_op[OP_QUERY],
			n_op[OP_ALLOCATE], n_op[OP_REQUEST], n_op[OP_RELEASE], n_op[OP_QUERY]);
		$display("Results: %0d ok, %0d store full, %0d block in use, %0d id out of range.",
			n_status[ST_OK], n_status[ST_FULL], n_status[ST_USED], n_status[ST_RANGE]);

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
